/* rtl/core/pmpl_pkg.sv */
// shared types and constants of the pulse meter power limiter
package pmpl_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEAS,
    S_MDIV,
    S_EVAL,
    S_EDIV,
    S_LIMIT,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_POWER,
    OP_DECAY,
    OP_DAMP,
    OP_BUS
  } div_op_t;

  // configuration register indexes
  localparam logic [2:0] REG_LIMIT_MODE    = 3'd0;
  localparam logic [2:0] REG_DAMPING       = 3'd1;
  localparam logic [2:0] REG_POWER_LIMIT   = 3'd2;
  localparam logic [2:0] REG_HYSTERESIS    = 3'd3;
  localparam logic [2:0] REG_METER_ENABLED = 3'd4;

  // limit modes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_MEAN   = 2'd1;
  localparam logic [1:0] MODE_DAMPED = 2'd2;
  localparam logic [1:0] MODE_BUS    = 2'd3;

  // start-up phases
  localparam logic [1:0] PH_RUN    = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_FIRST  = 2'd2;
  localparam logic [1:0] PH_LOAD   = 2'd3;

  // limit states
  localparam logic [1:0] LIM_OFF  = 2'd0;
  localparam logic [1:0] LIM_BAND = 2'd1;
  localparam logic [1:0] LIM_OVER = 2'd2;

  localparam logic [15:0] HOUR_TICKS       = 16'd36000;
  localparam logic [15:0] MIN_GAP          = 16'd10;
  localparam logic [6:0]  EVAL_LAST        = 7'd99;
  localparam logic [2:0]  EVALS_PER_MINUTE = 3'd6;
  localparam logic [19:0] BUS_SCALE        = 20'd1000;

  // serial divider sizes
  localparam int DIV_DVD_W = 48;
  localparam int DIV_DVS_W = 20;
  localparam int DIV_CNT_W = 6;

  function automatic logic [15:0] sat16(input logic [DIV_DVD_W-1:0] v);
    sat16 = (v > 48'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

/* rtl/core/pmpl_div.sv */
// restoring divider, one quotient bit per cycle
module pmpl_div
  import pmpl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [DIV_DVS_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_DVD_W-1:0] quotient
);

  logic [DIV_DVD_W-1:0] acc;
  logic [DIV_DVS_W-1:0] rem;
  logic [DIV_DVS_W-1:0] dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_DVS_W:0]   shifted;
  logic [DIV_DVS_W:0]   diff;
  logic                 ge;

  assign shifted  = {rem, acc[DIV_DVD_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign ge       = shifted >= {1'b0, dvs};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DVS_W-1:0] : shifted[DIV_DVS_W-1:0];
      acc <= {acc[DIV_DVD_W-2:0], ge};
    end
  end

endmodule

/* rtl/core/pulse_meter_power_limiter.sv */
// pulse meter power limiter top level
//
//  channel | signals                 | word
//  in      | in_valid / in_ready     | one 100 ms tick with meter count and powers
//  out     | out_valid / out_ready   | one result per tick
//  cfg     | cfg_we, cfg_index, data | register write, no wait
//
// a tick passes S_IDLE, S_MEAS, S_EVAL and S_OUT, with S_LIMIT before S_OUT on
// an evaluation tick; a pulse or a decay step adds a pass of the shared bit-serial
// divider (S_MDIV), and a damped or bus evaluation adds another (S_EDIV). one word
// is in flight at a time; a result held by out_ready stalls the next word only when
// it is finished. reset is synchronous; it spares the input and output data registers.
module pulse_meter_power_limiter
  import pmpl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] meter_count,
  input  logic        weight_too_large,
  input  logic [15:0] mean_power,
  input  logic [31:0] bus_power,
  input  logic        bus_power_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] instant_power,
  output logic [15:0] limit_power,
  output logic [1:0]  limit_state,
  output logic [15:0] limit_event_count,
  output logic [15:0] limit_minute_count,
  output logic        evaluated
);

  state_t state, state_next;

  logic [1:0]  limit_mode;
  logic [7:0]  damping;
  logic [15:0] power_limit;
  logic [15:0] hysteresis;
  logic        meter_enabled;

  logic [31:0] in_count;
  logic        in_wtl;
  logic [15:0] in_mean;
  logic [31:0] in_bus;
  logic        in_bus_valid;

  logic [6:0]  tick_div;
  logic        eval_tick;
  logic [1:0]  start_phase;
  logic [31:0] last_count;
  logic [15:0] ticks_since_pulse;
  logic [15:0] prev_interval;
  logic [15:0] power_now;
  logic [15:0] shown_power;
  logic [23:0] damped_fixed;
  logic [15:0] chosen_power;
  logic [1:0]  limit_flag;
  logic [2:0]  minute_div;
  logic [15:0] event_counter;
  logic [15:0] minute_counter;
  div_op_t     div_op;

  logic [15:0] t1;
  logic        cnt_gt, cnt_eq, running;
  logic [18:0] t1_w, p1, p2, p3, p4, p5;
  logic        decay_zero;
  logic [2:0]  decay_k;
  logic        need_power, need_decay, need_damp, need_bus;
  logic        div_start, div_done;
  logic [DIV_DVD_W-1:0] div_dividend, div_quot;
  logic [DIV_DVS_W-1:0] div_divisor;
  logic [DIV_DVD_W-1:0] pulse_num;
  logic [32:0] damp_num;
  logic [15:0] thr;
  logic [2:0]  md_inc;
  logic [6:0]  td_next;

  // measurement decode
  assign t1      = ticks_since_pulse + 16'd1;
  assign cnt_gt  = in_count > last_count;
  assign cnt_eq  = in_count == last_count;
  assign running = meter_enabled && !in_wtl && (start_phase == PH_RUN)
                   && (ticks_since_pulse < HOUR_TICKS);
  assign t1_w    = {3'b0, t1};
  assign p1      = {3'b0, prev_interval};
  assign p2      = {p1[17:0], 1'b0};
  assign p3      = p2 + p1;
  assign p4      = {p1[16:0], 2'b0};
  assign p5      = p4 + p1;
  assign decay_zero = (p5 < t1_w) || (prev_interval == 16'd0);

  // elapsed ticks lie between one and five intervals, so an exact multiple is 2..5
  always_comb begin
    decay_k = 3'd0;
    if (t1_w == p2) decay_k = 3'd2;
    else if (t1_w == p3) decay_k = 3'd3;
    else if (t1_w == p4) decay_k = 3'd4;
    else if (t1_w == p5) decay_k = 3'd5;
  end

  assign need_power = running && cnt_gt && (t1 >= MIN_GAP);
  assign need_decay = running && cnt_eq && (prev_interval < t1) && !decay_zero
                      && (decay_k != 3'd0);
  assign need_damp  = (limit_mode == MODE_DAMPED) && (chosen_power != 16'd0)
                      && (damping >= 8'd2);
  assign need_bus   = (limit_mode == MODE_BUS) && in_bus_valid;

  // round(36*d/t) = (360*d + 5*t) / (10*t)
  assign pulse_num = ({16'b0, in_count - last_count} << 8)
                   + ({16'b0, in_count - last_count} << 6)
                   + ({16'b0, in_count - last_count} << 5)
                   + ({16'b0, in_count - last_count} << 3)
                   + ({32'b0, t1} << 2) + {32'b0, t1};
  assign damp_num  = 33'(damped_fixed * (damping - 8'd1))
                   + {9'b0, shown_power, 8'b0} + {26'b0, damping[7:1]};

  always_comb begin
    div_dividend = {16'b0, in_bus};
    div_divisor  = BUS_SCALE;
    if (state == S_MEAS) begin
      if (need_power) begin
        div_dividend = pulse_num;
        div_divisor  = ({4'b0, t1} << 3) + ({4'b0, t1} << 1);
      end else begin
        div_dividend = {32'b0, power_now};
        div_divisor  = {17'b0, decay_k};
      end
    end else if (need_damp) begin
      div_dividend = {15'b0, damp_num};
      div_divisor  = {12'b0, damping};
    end
  end

  pmpl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MEAS;
      S_MEAS:  state_next = (need_power || need_decay) ? S_MDIV : S_EVAL;
      S_MDIV:  if (div_done) state_next = S_EVAL;
      S_EVAL: begin
        if (!eval_tick) state_next = S_OUT;
        else if (need_damp || need_bus) state_next = S_EDIV;
        else state_next = S_LIMIT;
      end
      S_EDIV:  if (div_done) state_next = S_LIMIT;
      S_LIMIT: state_next = S_OUT;
      S_OUT:   if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    div_start = 1'b0;
    case (state)
      S_MEAS:  div_start = need_power || need_decay;
      S_EVAL:  div_start = eval_tick && (need_damp || need_bus);
      default: div_start = 1'b0;
    endcase
  end

  assign td_next = (tick_div == EVAL_LAST) ? 7'd0 : tick_div + 7'd1;
  assign thr     = (hysteresis >= power_limit) ? 16'd0 : power_limit - hysteresis;
  assign md_inc  = minute_div + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_mode    <= MODE_NONE;
      damping       <= '0;
      power_limit   <= '0;
      hysteresis    <= '0;
      meter_enabled <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIMIT_MODE:    limit_mode    <= cfg_data[1:0];
        REG_DAMPING:       damping       <= cfg_data[7:0];
        REG_POWER_LIMIT:   power_limit   <= cfg_data;
        REG_HYSTERESIS:    hysteresis    <= cfg_data;
        REG_METER_ENABLED: meter_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      in_count     <= meter_count;
      in_wtl       <= weight_too_large;
      in_mean      <= mean_power;
      in_bus       <= bus_power;
      in_bus_valid <= bus_power_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_div          <= '0;
      eval_tick         <= 1'b0;
      start_phase       <= PH_LOAD;
      last_count        <= '0;
      ticks_since_pulse <= '0;
      prev_interval     <= '0;
      power_now         <= '0;
      shown_power       <= '0;
      damped_fixed      <= '0;
      chosen_power      <= '0;
      limit_flag        <= LIM_OFF;
      minute_div        <= '0;
      event_counter     <= '0;
      minute_counter    <= '0;
      div_op            <= OP_POWER;
      out_valid         <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tick_div  <= td_next;
            eval_tick <= (td_next == 7'd0);
          end
        end
        S_MEAS: begin
          div_op <= need_power ? OP_POWER : OP_DECAY;
          if (meter_enabled) begin
            if (in_wtl) begin
              limit_flag <= LIM_OFF;
            end else begin
              case (start_phase)
                PH_LOAD: begin
                  last_count   <= in_count;
                  limit_flag   <= LIM_OFF;
                  shown_power  <= '0;
                  chosen_power <= '0;
                  damped_fixed <= '0;
                  start_phase  <= PH_FIRST;
                end
                PH_FIRST: begin
                  if (!cnt_eq) begin
                    last_count  <= in_count;
                    start_phase <= PH_SECOND;
                  end
                end
                PH_SECOND: begin
                  if (!cnt_eq) begin
                    ticks_since_pulse <= '0;
                    prev_interval     <= '0;
                    last_count        <= in_count;
                    start_phase       <= PH_RUN;
                  end
                end
                default: begin
                  if (ticks_since_pulse < HOUR_TICKS) begin
                    ticks_since_pulse <= t1;
                    shown_power       <= power_now;
                    if (cnt_gt) begin
                      if (t1 >= MIN_GAP) begin
                        last_count        <= in_count;
                        prev_interval     <= t1;
                        ticks_since_pulse <= '0;
                      end
                    end else if (cnt_eq) begin
                      if (prev_interval < t1 && decay_zero) begin
                        power_now   <= '0;
                        shown_power <= '0;
                      end
                    end else begin
                      // count went backward
                      power_now         <= '0;
                      shown_power       <= '0;
                      last_count        <= in_count;
                      prev_interval     <= t1;
                      ticks_since_pulse <= '0;
                    end
                  end else begin
                    power_now   <= '0;
                    shown_power <= '0;
                    if (!cnt_eq) begin
                      last_count        <= in_count;
                      prev_interval     <= ticks_since_pulse;
                      ticks_since_pulse <= '0;
                    end
                  end
                end
              endcase
            end
          end
        end
        S_MDIV: begin
          if (div_done) begin
            power_now   <= sat16(div_quot);
            shown_power <= sat16(div_quot);
          end
        end
        S_EVAL: begin
          div_op <= need_damp ? OP_DAMP : OP_BUS;
          if (eval_tick) begin
            case (limit_mode)
              MODE_DAMPED: begin
                if (!need_damp) begin
                  chosen_power <= shown_power;
                  damped_fixed <= {shown_power, 8'b0};
                end
              end
              MODE_MEAN: chosen_power <= meter_enabled ? in_mean : shown_power;
              MODE_BUS:  if (!in_bus_valid) chosen_power <= '0;
              default:   chosen_power <= '0;
            endcase
          end
        end
        S_EDIV: begin
          if (div_done) begin
            if (div_op == OP_DAMP) begin
              damped_fixed <= div_quot[23:0];
              chosen_power <= sat16({23'b0, div_quot[23:0] + 25'd128} >> 8);
            end else begin
              chosen_power <= sat16(div_quot);
            end
          end
        end
        S_LIMIT: begin
          if (power_limit != 16'd0 && hysteresis != 16'd0 && chosen_power >= thr) begin
            if (limit_flag == LIM_OFF) event_counter <= event_counter + 16'd1;
            if (md_inc >= EVALS_PER_MINUTE) begin
              minute_div     <= '0;
              minute_counter <= minute_counter + 16'd1;
            end else begin
              minute_div <= md_inc;
            end
            limit_flag <= (chosen_power >= power_limit) ? LIM_OVER : LIM_BAND;
          end else begin
            limit_flag <= LIM_OFF;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      instant_power      <= shown_power;
      limit_power        <= chosen_power;
      limit_state        <= limit_flag;
      limit_event_count  <= event_counter;
      limit_minute_count <= minute_counter;
      evaluated          <= eval_tick;
    end
  end

endmodule

/* rtl/core/pmpl_chk.sv */
// port checker for the pulse meter power limiter
module pmpl_chk
  import pmpl_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] limit_state
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one word at a time
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  a_state_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (limit_state == LIM_OFF || limit_state == LIM_BAND
                   || limit_state == LIM_OVER))
    else $error("bad limit state");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind pulse_meter_power_limiter pmpl_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .limit_state (limit_state)
);
